### rtl/mmp_pkg.sv
// Shared widths, pipeline record types and the arctangent table of the magnitude/phase block.
package mmp_pkg;

  localparam int SAMPLE_W     = 16;
  localparam int OUT_W        = 17;
  localparam int CNT_W        = 2;
  localparam logic [CNT_W-1:0] CNT_RESET = 2'd2;
  localparam int MAX_CHANNELS = 3;

  // Rotation datapath: 19 integer bits cover the CORDIC gain on a full-scale vector.
  localparam int FRAC         = 32;
  localparam int XW           = FRAC + 19;
  localparam int ACC_W        = 34;
  localparam int CORDIC_ITERS = 30;

  // Square root: one result bit per cell.
  localparam int SUM_W        = 32;
  localparam int ROOT_DIGITS  = SUM_W / 2;

  // The rounded amplitude leaves the root chain earlier than the phase leaves the rotation
  // chain; this many registers line them up.
  localparam int AMP_DELAY    = (CORDIC_ITERS + 1) - (ROOT_DIGITS + 2);

  typedef struct packed {
    logic                    valid;
    logic                    single;
    logic                    zero;
    logic signed [XW-1:0]    x;
    logic signed [XW-1:0]    y;
    logic signed [ACC_W-1:0] acc;
  } cordic_t;

  typedef struct packed {
    logic                       single;
    logic signed [SAMPLE_W-1:0] c0;
    logic [SUM_W-1:0]           rem;
    logic [SUM_W-1:0]           root;
  } sqrt_t;

  // Angle of 2^-i in units where 2^32 is a full turn.
  function automatic logic [ACC_W-1:0] atan_turn(input int unsigned i);
    logic [ACC_W-1:0] t;
    case (i)
      0:  t = 34'd536870912;
      1:  t = 34'd316933406;
      2:  t = 34'd167458907;
      3:  t = 34'd85004756;
      4:  t = 34'd42667331;
      5:  t = 34'd21354465;
      6:  t = 34'd10679838;
      7:  t = 34'd5340245;
      8:  t = 34'd2670163;
      9:  t = 34'd1335087;
      10: t = 34'd667544;
      11: t = 34'd333772;
      12: t = 34'd166886;
      13: t = 34'd83443;
      14: t = 34'd41722;
      15: t = 34'd20861;
      16: t = 34'd10430;
      17: t = 34'd5215;
      18: t = 34'd2608;
      19: t = 34'd1304;
      20: t = 34'd652;
      21: t = 34'd326;
      22: t = 34'd163;
      23: t = 34'd81;
      24: t = 34'd41;
      25: t = 34'd20;
      26: t = 34'd10;
      27: t = 34'd5;
      28: t = 34'd3;
      29: t = 34'd1;
      default: t = '0;
    endcase
    return t;
  endfunction

endpackage

### rtl/mmp_ifs.sv
// Valid/ready channel interfaces for samples, results and the channel count register.
interface mmp_sample_if;
  logic                                valid;
  logic                                ready;
  logic signed [mmp_pkg::SAMPLE_W-1:0] chan0_value;
  logic signed [mmp_pkg::SAMPLE_W-1:0] chan1_value;
  logic signed [mmp_pkg::SAMPLE_W-1:0] chan2_value;
  modport source (output valid, chan0_value, chan1_value, chan2_value, input ready);
  modport sink   (input valid, chan0_value, chan1_value, chan2_value, output ready);
endinterface

interface mmp_result_if;
  logic                             valid;
  logic                             ready;
  logic signed [mmp_pkg::OUT_W-1:0] amplitude;
  logic signed [mmp_pkg::OUT_W-1:0] phase_angle;
  modport source (output valid, amplitude, phase_angle, input ready);
  modport sink   (input valid, amplitude, phase_angle, output ready);
endinterface

interface mmp_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [mmp_pkg::CNT_W-1:0]    channel_count;
  modport source (output valid, channel_count, input ready);
  modport sink   (input valid, channel_count, output ready);
endinterface

### rtl/multichannel_magnitude_phase.sv
// Top level: magnitude and phase of a multi-channel sample through two chains of cells.
//
// A sample request carries three signed 16-bit channel values. Each accepted request gives
// exactly one result request: the amplitude (the rounded root of the sum of squares over the
// active channels, or channel 0 itself with one channel) and the phase atan2(chan1, chan0)
// in binary angle units where 32768 is pi, or zero with one channel.
// The cfg channel writes the active channel count; it is always ready and should be written
// only while no sample is in flight.
// Throughput is one sample per cycle unless a stalled receiver holds the pipeline. A sample
// passes one input register, 31 registered cells of the rotation chain (one pre-rotation
// and 30 micro-rotations, which set the depth), and the output register. The root chain
// (squares, sum, 16 digit cells, rounding) runs alongside and is delayed to match.
// When the receiver stalls, the result stays in the output register and the whole pipeline
// holds only once a finished result reaches its last stage; until then samples are still
// taken and bubbles are squeezed out. Reset empties the pipeline and sets the channel
// count to 2.
module multichannel_magnitude_phase (
  input logic                clk,
  input logic                rst,
  mmp_sample_if.sink         sample,
  mmp_result_if.source       result,
  mmp_cfg_if.sink            cfg
);

  localparam int SW = mmp_pkg::SAMPLE_W;
  localparam int OW = mmp_pkg::OUT_W;
  localparam int NI = mmp_pkg::CORDIC_ITERS;
  localparam int ND = mmp_pkg::ROOT_DIGITS;
  localparam int DL = mmp_pkg::AMP_DELAY;

  logic                          en;
  logic [mmp_pkg::CNT_W-1:0]     channel_count;

  logic                          in_valid;
  logic                          in_single;
  logic                          in_use2;
  logic signed [SW-1:0]          in_c0;
  logic signed [SW-1:0]          in_c1;
  logic signed [SW-1:0]          in_c2;

  logic signed [2*SW-1:0]        p0;
  logic signed [2*SW-1:0]        p1;
  logic signed [2*SW-1:0]        p2;
  logic [2*SW-2:0]               sq0;
  logic [2*SW-2:0]               sq1;
  logic [2*SW-2:0]               sq2;
  logic                          sq_single;
  logic signed [SW-1:0]          sq_c0;

  mmp_pkg::cordic_t              pre;
  mmp_pkg::cordic_t              cord [NI+1];
  mmp_pkg::sqrt_t                sum_in;
  mmp_pkg::sqrt_t                sqr [ND+1];

  logic signed [OW-1:0]          amp_round;
  logic signed [OW-1:0]          amp_dly [DL];

  logic signed [mmp_pkg::ACC_W-1:0]    acc_rnd;
  logic signed [mmp_pkg::ACC_W-17:0]   ph_full;
  logic signed [OW-1:0]                phase_next;

  logic                          out_valid;
  logic signed [OW-1:0]          amplitude;
  logic signed [OW-1:0]          phase_angle;

  // The pipeline moves unless a finished result is blocked behind a waiting one.
  assign en = !out_valid || result.ready || !cord[NI].valid;
  assign sample.ready = en;
  assign cfg.ready    = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_count <= mmp_pkg::CNT_RESET;
    end else if (cfg.valid) begin
      channel_count <= cfg.channel_count;
    end
  end

  // Input register. A count of zero acts as one channel, above the maximum as the maximum.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (en) begin
      in_valid <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      in_c0     <= sample.chan0_value;
      in_c1     <= sample.chan1_value;
      in_c2     <= sample.chan2_value;
      in_single <= channel_count <= mmp_pkg::CNT_W'(1);
      in_use2   <= channel_count >= mmp_pkg::CNT_W'(mmp_pkg::MAX_CHANNELS)
                   && mmp_pkg::MAX_CHANNELS > 2;
    end
  end

  // Root chain: squares, sum, then one digit per cell.
  assign p0 = in_c0 * in_c0;
  assign p1 = in_c1 * in_c1;
  assign p2 = in_c2 * in_c2;

  always_ff @(posedge clk) begin
    if (en) begin
      sq0       <= p0[2*SW-2:0];
      sq1       <= p1[2*SW-2:0];
      sq2       <= in_use2 ? p2[2*SW-2:0] : '0;
      sq_single <= in_single;
      sq_c0     <= in_c0;
    end
  end

  always_comb begin
    sum_in.single = sq_single;
    sum_in.c0     = sq_c0;
    sum_in.rem    = mmp_pkg::SUM_W'(sq0) + mmp_pkg::SUM_W'(sq1) + mmp_pkg::SUM_W'(sq2);
    sum_in.root   = '0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sqr[0] <= sum_in;
    end
  end

  for (genvar j = 0; j < ND; j++) begin : g_sqrt
    mmp_sqrt_cell #(.STAGE(j)) u_cell (
      .clk (clk),
      .en  (en),
      .d   (sqr[j]),
      .q   (sqr[j+1])
    );
  end

  // Round to nearest: the remainder left over is S - n*n, so S > n*n + n means rem > n.
  always_comb begin
    if (sqr[ND].single) begin
      amp_round = OW'(sqr[ND].c0);
    end else begin
      amp_round = $signed({1'b0, sqr[ND].root[ND-1:0]})
                  + $signed({{(OW-1){1'b0}}, sqr[ND].rem > sqr[ND].root});
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      amp_dly[0] <= amp_round;
      for (int k = 1; k < DL; k++) begin
        amp_dly[k] <= amp_dly[k-1];
      end
    end
  end

  // Rotation chain: quadrant correction for a negative real part, then the micro-rotations.
  always_comb begin
    pre.valid  = in_valid;
    pre.single = in_single;
    pre.zero   = (in_c0 == '0) && (in_c1 == '0);
    pre.x      = {{(mmp_pkg::XW-mmp_pkg::FRAC-SW){in_c0[SW-1]}}, in_c0,
                  {mmp_pkg::FRAC{1'b0}}};
    pre.y      = {{(mmp_pkg::XW-mmp_pkg::FRAC-SW){in_c1[SW-1]}}, in_c1,
                  {mmp_pkg::FRAC{1'b0}}};
    pre.acc    = '0;
    if (in_c0[SW-1]) begin
      if (!in_c1[SW-1]) begin
        pre.x   = {{(mmp_pkg::XW-mmp_pkg::FRAC-SW){in_c1[SW-1]}}, in_c1,
                   {mmp_pkg::FRAC{1'b0}}};
        pre.y   = -{{(mmp_pkg::XW-mmp_pkg::FRAC-SW){in_c0[SW-1]}}, in_c0,
                    {mmp_pkg::FRAC{1'b0}}};
        pre.acc = mmp_pkg::ACC_W'(34'sd1073741824);
      end else begin
        pre.x   = -{{(mmp_pkg::XW-mmp_pkg::FRAC-SW){in_c1[SW-1]}}, in_c1,
                    {mmp_pkg::FRAC{1'b0}}};
        pre.y   = {{(mmp_pkg::XW-mmp_pkg::FRAC-SW){in_c0[SW-1]}}, in_c0,
                   {mmp_pkg::FRAC{1'b0}}};
        pre.acc = -mmp_pkg::ACC_W'(34'sd1073741824);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cord[0].valid <= 1'b0;
    end else if (en) begin
      cord[0] <= pre;
    end
  end

  for (genvar i = 0; i < NI; i++) begin : g_cordic
    mmp_cordic_cell #(.STAGE(i)) u_cell (
      .clk (clk),
      .rst (rst),
      .en  (en),
      .d   (cord[i]),
      .q   (cord[i+1])
    );
  end

  // Angle in 2^-32 turns to units of pi/32768, rounded half up and clamped.
  assign acc_rnd = cord[NI].acc + mmp_pkg::ACC_W'(34'sd32768);
  assign ph_full = acc_rnd[mmp_pkg::ACC_W-1:16];

  always_comb begin
    if (cord[NI].single || cord[NI].zero) begin
      phase_next = '0;
    end else if (ph_full > (mmp_pkg::ACC_W-16)'(32768)) begin
      phase_next = OW'(32768);
    end else if (ph_full < -(mmp_pkg::ACC_W-16)'(32768)) begin
      phase_next = -OW'(32768);
    end else begin
      phase_next = ph_full[OW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      if (cord[NI].valid) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en && cord[NI].valid) begin
      amplitude   <= amp_dly[DL-1];
      phase_angle <= phase_next;
    end
  end

  assign result.valid       = out_valid;
  assign result.amplitude   = amplitude;
  assign result.phase_angle = phase_angle;

endmodule

### rtl/mmp_cordic_cell.sv
// One vectoring micro-rotation of the phase chain, with its output register.
module mmp_cordic_cell #(
  parameter int STAGE = 0
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  mmp_pkg::cordic_t d,
  output mmp_pkg::cordic_t q
);

  logic signed [mmp_pkg::XW-1:0]    dx;
  logic signed [mmp_pkg::XW-1:0]    dy;
  logic signed [mmp_pkg::ACC_W-1:0] turn;
  mmp_pkg::cordic_t                 q_next;

  assign dx   = d.y >>> STAGE;
  assign dy   = d.x >>> STAGE;
  assign turn = mmp_pkg::atan_turn(STAGE);

  always_comb begin
    q_next = d;
    // Rotate toward the positive real axis, judged by the sign of the current y.
    if (!d.y[mmp_pkg::XW-1]) begin
      q_next.x   = d.x + dx;
      q_next.y   = d.y - dy;
      q_next.acc = d.acc + turn;
    end else begin
      q_next.x   = d.x - dx;
      q_next.y   = d.y + dy;
      q_next.acc = d.acc - turn;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else if (en) begin
      q <= q_next;
    end
  end

endmodule

### rtl/mmp_sqrt_cell.sv
// One digit of the restoring square root, with its output register.
module mmp_sqrt_cell #(
  parameter int STAGE = 0
) (
  input  logic           clk,
  input  logic           en,
  input  mmp_pkg::sqrt_t d,
  output mmp_pkg::sqrt_t q
);

  localparam logic [mmp_pkg::SUM_W-1:0] BIT =
    {{(mmp_pkg::SUM_W-1){1'b0}}, 1'b1} << (2 * (mmp_pkg::ROOT_DIGITS - 1 - STAGE));

  logic [mmp_pkg::SUM_W:0] trial;
  logic                    take;
  mmp_pkg::sqrt_t          q_next;

  assign trial = {1'b0, d.root} + {1'b0, BIT};
  assign take  = {1'b0, d.rem} >= trial;

  always_comb begin
    q_next = d;
    if (take) begin
      q_next.rem  = d.rem - trial[mmp_pkg::SUM_W-1:0];
      q_next.root = (d.root >> 1) + BIT;
    end else begin
      q_next.root = d.root >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q <= q_next;
    end
  end

endmodule

### tb/mmp_checker.sv
// Checker that predicts amplitude and phase of every accepted sample and compares the results.
`timescale 1ns / 1ps
module mmp_checker (
  input  logic  clk,
  input  logic  rst,
  mmp_sample_if sample,
  mmp_result_if result,
  mmp_cfg_if    cfg,
  output int    errors,
  output int    pending
);

  localparam real PI        = 3.14159265358979323846;
  localparam int  MAX_SHOWN = 100;

  typedef struct {
    logic signed [mmp_pkg::SAMPLE_W-1:0] c0;
    logic signed [mmp_pkg::SAMPLE_W-1:0] c1;
    logic signed [mmp_pkg::SAMPLE_W-1:0] c2;
    logic [mmp_pkg::OUT_W-1:0]           amp;
    logic [mmp_pkg::OUT_W-1:0]           phase;
  } amp_phase_t;

  amp_phase_t                due_amp_phase [$];
  logic [mmp_pkg::CNT_W-1:0] active_count;
  longint                    turn_step [mmp_pkg::CORDIC_ITERS];
  int                        mismatches = 0;

  // Angle of each micro-rotation, with a full turn equal to 2^32.
  initial begin
    for (int i = 0; i < mmp_pkg::CORDIC_ITERS; i++)
      turn_step[i] = longint'($rtoi($atan(2.0 ** (-i)) * 4294967296.0 / (2.0 * PI) + 0.5));
  end

  function automatic logic [mmp_pkg::OUT_W-1:0] rounded_root(input longint sum_sq);
    longint root;
    longint trial;
    root = 0;
    for (int b = 15; b >= 0; b--) begin
      trial = root | (longint'(1) << b);
      if (trial * trial <= sum_sq) root = trial;
    end
    // The exact root is never a half integer, so this comparison rounds to nearest.
    if (sum_sq > root * root + root) root = root + 1;
    return root[mmp_pkg::OUT_W-1:0];
  endfunction

  function automatic logic [mmp_pkg::OUT_W-1:0] binary_angle(input longint re,
                                                             input longint im);
    longint x;
    longint y;
    longint acc;
    longint dx;
    longint dy;
    longint p;
    if (re == 0 && im == 0) return '0;
    x   = re * 64'sd4294967296;
    y   = im * 64'sd4294967296;
    acc = 0;
    // Vectors in the left half plane are first turned by a quarter turn.
    if (x < 0) begin
      dx = x;
      if (y >= 0) begin
        x   = y;
        y   = -dx;
        acc = 64'sd1073741824;
      end else begin
        x   = -y;
        y   = dx;
        acc = -64'sd1073741824;
      end
    end
    for (int i = 0; i < mmp_pkg::CORDIC_ITERS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x   = x + dx;
        y   = y - dy;
        acc = acc + turn_step[i];
      end else begin
        x   = x - dx;
        y   = y + dy;
        acc = acc - turn_step[i];
      end
    end
    p = (acc + 32768) >>> 16;
    if (p > 32768) p = 32768;
    if (p < -32768) p = -32768;
    return p[mmp_pkg::OUT_W-1:0];
  endfunction

  function automatic amp_phase_t predict_amp_phase(
    input logic signed [mmp_pkg::SAMPLE_W-1:0] c0,
    input logic signed [mmp_pkg::SAMPLE_W-1:0] c1,
    input logic signed [mmp_pkg::SAMPLE_W-1:0] c2,
    input logic [mmp_pkg::CNT_W-1:0]           count);
    amp_phase_t e;
    int         n;
    longint     sum_sq;
    e.c0 = c0;
    e.c1 = c1;
    e.c2 = c2;
    n = (count == 0) ? 1 : int'(count);
    if (n > mmp_pkg::MAX_CHANNELS) n = mmp_pkg::MAX_CHANNELS;
    if (n == 1) begin
      e.amp   = mmp_pkg::OUT_W'(int'(c0));
      e.phase = '0;
    end else begin
      sum_sq = longint'(c0) * longint'(c0) + longint'(c1) * longint'(c1);
      if (n > 2) sum_sq = sum_sq + longint'(c2) * longint'(c2);
      e.amp   = rounded_root(sum_sq);
      e.phase = binary_angle(longint'(c0), longint'(c1));
    end
    return e;
  endfunction

  always @(posedge clk) begin
    amp_phase_t e;
    if (rst) begin
      active_count = mmp_pkg::CNT_RESET;
      due_amp_phase.delete();
    end else begin
      if (result.valid && result.ready) begin
        if (due_amp_phase.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN)
            $display("%0t: result request with no sample pending: expected none, got %0d / %0d",
                     $time, result.amplitude, result.phase_angle);
        end else begin
          e = due_amp_phase.pop_front();
          if (result.amplitude !== e.amp) begin
            mismatches++;
            if (mismatches <= MAX_SHOWN)
              $display("%0t: amplitude of (%0d, %0d, %0d): expected %0d, got %0d",
                       $time, e.c0, e.c1, e.c2, $signed(e.amp), result.amplitude);
          end
          if (result.phase_angle !== e.phase) begin
            mismatches++;
            if (mismatches <= MAX_SHOWN)
              $display("%0t: phase of (%0d, %0d, %0d): expected %0d, got %0d",
                       $time, e.c0, e.c1, e.c2, $signed(e.phase), result.phase_angle);
          end
        end
      end
      // Each sample request yields exactly one expected result.
      if (sample.valid && sample.ready)
        due_amp_phase.push_back(predict_amp_phase(sample.chan0_value, sample.chan1_value,
                                                  sample.chan2_value, active_count));
      if (cfg.valid && cfg.ready) active_count = cfg.channel_count;
    end
    errors  <= mismatches;
    pending <= due_amp_phase.size();
  end

endmodule

### tb/multichannel_magnitude_phase_tb.sv
// Testbench top: clock, reset, sample and channel count stimulus, result back-pressure, verdict.
`timescale 1ns / 1ps
module multichannel_magnitude_phase_tb;

  localparam int IDLE_LIMIT  = 3000;
  localparam int HOLD_CYCLES = 400;
  localparam int PIPE_DRAIN  = 40;
  localparam int PHASE_ITEMS = 125;

  localparam logic signed [mmp_pkg::SAMPLE_W-1:0] MOST_NEG =
    {1'b1, {(mmp_pkg::SAMPLE_W-1){1'b0}}};
  localparam logic signed [mmp_pkg::SAMPLE_W-1:0] MOST_POS = ~MOST_NEG;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   errors;
  int   pending;
  int   idle_cycles = 0;
  int   rx_hold = 0;
  bit   tx_steady = 1'b0;
  bit   rx_steady = 1'b0;
  bit   tx_burst = 1'b0;

  mmp_sample_if sample_ch();
  mmp_result_if result_ch();
  mmp_cfg_if    cfg_ch();

  multichannel_magnitude_phase u_top (
    .clk    (clk),
    .rst    (rst),
    .sample (sample_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  mmp_checker u_checker (
    .clk     (clk),
    .rst     (rst),
    .sample  (sample_ch),
    .result  (result_ch),
    .cfg     (cfg_ch),
    .errors  (errors),
    .pending (pending)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst || (sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (idle_cycles >= IDLE_LIMIT);
    $display("DONE: errors detected");
    $finish;
  end

  // Result side: random stalls, steady stretches, and one long hold-off on request.
  initial begin
    int gap;
    result_ch.ready <= 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (rx_hold > 0) begin
        gap     = rx_hold;
        rx_hold = 0;
      end else begin
        if ($urandom_range(0, 39) == 0) rx_steady = !rx_steady;
        gap = rx_steady ? 0 : $urandom_range(0, 13);
      end
      if (gap > 0) begin
        result_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      result_ch.ready <= 1'b1;
      do @(posedge clk); while (!result_ch.valid);
    end
  end

  task automatic push_sample(input logic signed [mmp_pkg::SAMPLE_W-1:0] c0,
                             input logic signed [mmp_pkg::SAMPLE_W-1:0] c1,
                             input logic signed [mmp_pkg::SAMPLE_W-1:0] c2);
    int gap;
    if (!tx_burst && $urandom_range(0, 39) == 0) tx_steady = !tx_steady;
    gap = (tx_burst || tx_steady) ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      sample_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_ch.chan0_value <= c0;
    sample_ch.chan1_value <= c1;
    sample_ch.chan2_value <= c2;
    sample_ch.valid       <= 1'b1;
    do @(posedge clk); while (!sample_ch.ready);
  endtask

  function automatic logic signed [mmp_pkg::SAMPLE_W-1:0] random_sample_value();
    case ($urandom_range(0, 9))
      0:       return MOST_NEG;
      1:       return MOST_POS;
      2:       return '0;
      3:       return mmp_pkg::SAMPLE_W'(int'($urandom_range(0, 8)) - 4);
      4:       return mmp_pkg::SAMPLE_W'(int'($urandom_range(0, 511)) - 256);
      default: return mmp_pkg::SAMPLE_W'($urandom);
    endcase
  endfunction

  task automatic push_random_sample();
    logic signed [mmp_pkg::SAMPLE_W-1:0] a;
    logic signed [mmp_pkg::SAMPLE_W-1:0] b;
    logic signed [mmp_pkg::SAMPLE_W-1:0] c;
    a = random_sample_value();
    b = random_sample_value();
    c = random_sample_value();
    // Now and then put the vector on the real axis or on a diagonal.
    case ($urandom_range(0, 15))
      0:       b = '0;
      1:       b = a;
      2:       b = -a;
      default: ;
    endcase
    push_sample(a, b, c);
  endtask

  task automatic wait_all_results();
    sample_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_channel_count(input logic [mmp_pkg::CNT_W-1:0] count);
    wait_all_results();
    cfg_ch.channel_count <= count;
    cfg_ch.valid         <= 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin
    logic [mmp_pkg::CNT_W-1:0] phase_counts [6];
    phase_counts = '{2'd3, 2'd1, 2'd2, 2'd0, 2'd3, 2'd2};
    sample_ch.valid       <= 1'b0;
    sample_ch.chan0_value <= '0;
    sample_ch.chan1_value <= '0;
    sample_ch.chan2_value <= '0;
    cfg_ch.valid          <= 1'b0;
    cfg_ch.channel_count  <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Two channels, the count left by reset.
    push_sample('0, '0, '0);
    push_sample(MOST_NEG, '0, '0);
    push_sample(-16'sd1, '0, '0);
    push_sample(MOST_POS, MOST_POS, '0);
    push_sample(MOST_NEG, MOST_NEG, MOST_POS);
    push_sample('0, MOST_POS, '0);
    push_sample('0, MOST_NEG, '0);
    push_sample(16'sd1, -16'sd1, '0);

    write_channel_count(2'd3);
    push_sample(MOST_NEG, MOST_NEG, MOST_NEG);
    push_sample(MOST_POS, MOST_NEG, MOST_POS);
    push_sample('0, '0, MOST_NEG);
    push_sample(16'sd3, 16'sd4, 16'sd12);

    write_channel_count(2'd1);
    push_sample(MOST_NEG, MOST_POS, MOST_POS);
    push_sample(MOST_POS, MOST_NEG, MOST_NEG);
    push_sample('0, 16'sd100, 16'sd100);

    // A count of zero behaves as a single channel.
    write_channel_count(2'd0);
    push_sample(-16'sd5, 16'sd100, 16'sd100);
    push_sample(MOST_NEG, '0, '0);

    write_channel_count(2'd2);
    push_sample(-16'sd7, '0, '0);
    push_sample(MOST_NEG, 16'sd1, '0);
    push_sample(MOST_NEG, -16'sd1, '0);

    foreach (phase_counts[p]) begin
      write_channel_count(phase_counts[p]);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        // The receiver stops for a long time while samples keep coming, so the pipeline
        // fills and the input stalls.
        if (p == 1 && k == 20) begin
          rx_hold  = HOLD_CYCLES;
          tx_burst = 1'b1;
        end
        if (p == 1 && k == 100) tx_burst = 1'b0;
        if (p == 3 && k == 60) wait_all_results();
        push_random_sample();
      end
    end

    wait_all_results();
    repeat (PIPE_DRAIN) @(posedge clk);
    if (errors == 0 && pending == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

### filelist.f
rtl/mmp_pkg.sv
rtl/mmp_ifs.sv
rtl/mmp_cordic_cell.sv
rtl/mmp_sqrt_cell.sv
rtl/multichannel_magnitude_phase.sv
tb/mmp_checker.sv
tb/multichannel_magnitude_phase_tb.sv
